// ===== hdl/bounded_sorted_priority_queue_macros.svh =====
// Assertion helpers for the sorted priority queue.
`ifndef BOUNDED_SORTED_PRIORITY_QUEUE_MACROS_SVH
`define BOUNDED_SORTED_PRIORITY_QUEUE_MACROS_SVH

`ifndef SYNTHESIS
`define BSQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BSQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BSQ_ASSERT_IMP(lbl, ante, cons, msg)
`define BSQ_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

// ===== hdl/bsq_pkg.sv =====
`default_nettype none
package bsq_pkg;

  localparam int OP_W     = 2;
  localparam int EXT_ID_W = 16;
  localparam int INI_W    = 8;
  localparam int AGE_W    = 16;
  localparam int POS_W    = 4;
  localparam int CNT_W    = 5;
  localparam int CAP_W    = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_READ   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_REM,
    S_RD,
    S_PUT,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    where;
    logic [CNT_W-1:0]    count;
    logic [EXT_ID_W-1:0] id;
    logic [INI_W-1:0]    ini;
    logic [AGE_W-1:0]    age;
  } res_t;

endpackage
`default_nettype wire

// ===== hdl/bsq_if.sv =====
`default_nettype none
interface bsq_in_if import bsq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [EXT_ID_W-1:0] entry_id;
  logic [INI_W-1:0]    initiative;
  logic [AGE_W-1:0]    age;
  logic [POS_W-1:0]    position;

  modport source (output valid, opcode, entry_id, initiative, age, position, input ready);
  modport sink   (input valid, opcode, entry_id, initiative, age, position, output ready);
endinterface

interface bsq_out_if import bsq_pkg::*; ();
  logic                valid;
  logic                ready;
  status_t             status;
  logic [POS_W-1:0]    where;
  logic [CNT_W-1:0]    count;
  logic [EXT_ID_W-1:0] out_id;
  logic [INI_W-1:0]    out_initiative;
  logic [AGE_W-1:0]    out_age;

  modport source (output valid, status, where, count, out_id, out_initiative, out_age,
                  input ready);
  modport sink   (input valid, status, where, count, out_id, out_initiative, out_age,
                  output ready);
endinterface
`default_nettype wire

// ===== hdl/bsq_mem.sv =====
`default_nettype none
module bsq_mem #(
  parameter int DEPTH = 16,
  parameter int EW    = 40,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [EW-1:0] rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [EW-1:0] wdata
);

  logic [EW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bsq_ctrl.sv =====
`default_nettype none
module bsq_ctrl import bsq_pkg::*; #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 16,
  localparam int AW     = $clog2(DEPTH),
  localparam int EW     = ID_BITS + INI_W + AGE_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  bsq_in_if.sink           req,
  output logic             mem_re,
  output logic [AW-1:0]    mem_raddr,
  input  logic [EW-1:0]    mem_rdata,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [EW-1:0]    mem_wdata,
  output res_t             res,
  output logic             res_load,
  input  logic             res_free
);

  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = (CW > CNT_W) ? CW : CNT_W;

  state_t state, state_next;

  logic [CW-1:0]      cnt, cnt_next;
  logic [CAP_W-1:0]   cap;
  logic [ID_BITS-1:0] op_id;
  logic [INI_W-1:0]   op_ini;
  logic [AGE_W-1:0]   op_age;
  logic [AW-1:0]      ra, ra_next;
  logic               ra_ok, ra_ok_next;
  logic [AW-1:0]      pa, pa_next;
  logic               found, found_next;
  logic [AW-1:0]      idx, idx_next;
  res_t               pend, pend_next;

  logic               acc;
  logic [ID_BITS-1:0] in_id;
  logic [CMPW-1:0]    lim;
  logic               full;
  logic               pos_bad;
  logic [ID_BITS-1:0] rd_id;
  logic [INI_W-1:0]   rd_ini;
  logic [AGE_W-1:0]   rd_age;
  logic               slot_le;
  logic               match;
  logic               last;
  logic [AW-1:0]      tail;

  function automatic res_t mk_res(status_t st, logic [POS_W-1:0] wh, logic [CNT_W-1:0] ct);
    res_t r;
    r.status = st;
    r.where  = wh;
    r.count  = ct;
    r.id     = '0;
    r.ini    = '0;
    r.age    = '0;
    return r;
  endfunction

  assign req.ready = (state == S_IDLE);
  assign acc       = req.valid && req.ready;
  assign in_id     = ID_BITS'(req.entry_id);

  assign lim     = (CMPW'(cap) > CMPW'(DEPTH)) ? CMPW'(DEPTH) : CMPW'(cap);
  assign full    = CMPW'(cnt) >= lim;
  assign pos_bad = CMPW'(req.position) >= CMPW'(cnt);
  assign tail    = AW'(cnt - CW'(1));

  assign rd_id  = mem_rdata[EW-1 -: ID_BITS];
  assign rd_ini = mem_rdata[AGE_W +: INI_W];
  assign rd_age = mem_rdata[AGE_W-1:0];

  // new entry goes ahead of this slot
  assign slot_le = (op_ini > rd_ini) || ((op_ini == rd_ini) && (op_age >= rd_age));
  assign match   = (rd_id == op_id);
  assign last    = (CMPW'(pa) + CMPW'(1)) == CMPW'(cnt);

  assign res      = pend;
  assign res_load = (state == S_DONE) && res_free;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (req.opcode)
            OP_INSERT: state_next = full ? S_DONE : ((cnt == '0) ? S_PUT : S_INS);
            OP_REMOVE: state_next = (cnt == '0) ? S_DONE : S_REM;
            OP_READ:   state_next = pos_bad ? S_DONE : S_RD;
            default:   state_next = S_DONE;
          endcase
        end
      end
      S_INS: begin
        if (!slot_le || (pa == '0)) begin
          state_next = S_PUT;
        end
      end
      S_REM: begin
        if (last) begin
          state_next = S_DONE;
        end
      end
      S_RD:    state_next = S_DONE;
      S_PUT:   state_next = S_DONE;
      S_DONE: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_re     = 1'b0;
    mem_raddr  = ra;
    mem_we     = 1'b0;
    mem_waddr  = pa;
    mem_wdata  = mem_rdata;
    cnt_next   = cnt;
    ra_next    = ra;
    ra_ok_next = ra_ok;
    pa_next    = pa;
    found_next = found;
    idx_next   = idx;
    pend_next  = pend;
    case (state)
      S_IDLE: begin
        if (acc) begin
          case (req.opcode)
            OP_INSERT: begin
              if (full) begin
                pend_next = mk_res(ST_FULL, '0, CNT_W'(cnt));
              end else if (cnt == '0) begin
                idx_next = '0;
              end else begin
                // scan from the tail towards the head
                mem_re     = 1'b1;
                mem_raddr  = tail;
                pa_next    = tail;
                ra_next    = tail - AW'(1);
                ra_ok_next = (tail != '0);
              end
            end
            OP_REMOVE: begin
              if (cnt == '0) begin
                pend_next = mk_res(ST_NOT_FOUND, '0, CNT_W'(cnt));
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                pa_next    = '0;
                ra_next    = AW'(1);
                ra_ok_next = CMPW'(cnt) > CMPW'(1);
                found_next = 1'b0;
              end
            end
            OP_READ: begin
              if (pos_bad) begin
                pend_next = mk_res(ST_EMPTY, req.position, CNT_W'(cnt));
              end else begin
                mem_re    = 1'b1;
                mem_raddr = AW'(req.position);
                pend_next = mk_res(ST_OK, req.position, CNT_W'(cnt));
              end
            end
            default: pend_next = mk_res(ST_OK, '0, CNT_W'(cnt));
          endcase
        end
      end
      S_INS: begin
        if (ra_ok) begin
          mem_re     = 1'b1;
          mem_raddr  = ra;
          pa_next    = ra;
          ra_next    = ra - AW'(1);
          ra_ok_next = (ra != '0);
        end
        if (slot_le) begin
          mem_we    = 1'b1;
          mem_waddr = pa + AW'(1);
          if (pa == '0) begin
            idx_next = '0;
          end
        end else begin
          mem_re     = 1'b0;
          idx_next   = pa + AW'(1);
          ra_ok_next = 1'b0;
        end
      end
      S_REM: begin
        if (ra_ok) begin
          mem_re     = 1'b1;
          mem_raddr  = ra;
          pa_next    = ra;
          ra_next    = ra + AW'(1);
          ra_ok_next = (CMPW'(ra) + CMPW'(1)) < CMPW'(cnt);
        end
        if (found) begin
          // close the gap
          mem_we    = 1'b1;
          mem_waddr = pa - AW'(1);
        end else if (match) begin
          found_next = 1'b1;
          idx_next   = pa;
        end
        if (last) begin
          ra_ok_next = 1'b0;
          if (found || match) begin
            cnt_next  = cnt - CW'(1);
            pend_next = mk_res(ST_OK, POS_W'(found ? idx : pa), CNT_W'(cnt - CW'(1)));
          end else begin
            pend_next = mk_res(ST_NOT_FOUND, '0, CNT_W'(cnt));
          end
        end
      end
      S_RD: begin
        pend_next.id  = EXT_ID_W'(rd_id);
        pend_next.ini = rd_ini;
        pend_next.age = rd_age;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = idx;
        mem_wdata = {op_id, op_ini, op_age};
        cnt_next  = cnt + CW'(1);
        pend_next = mk_res(ST_OK, POS_W'(idx), CNT_W'(cnt + CW'(1)));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      cap   <= CAP_RESET;
      ra_ok <= 1'b0;
      found <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ra_ok <= ra_ok_next;
      found <= found_next;
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    ra   <= ra_next;
    pa   <= pa_next;
    idx  <= idx_next;
    pend <= pend_next;
    if (acc) begin
      op_id  <= in_id;
      op_ini <= req.initiative;
      op_age <= req.age;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/bsq_out_stage.sv =====
`default_nettype none
module bsq_out_stage import bsq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  res_t res,
  input  logic res_load,
  output logic res_free,
  bsq_out_if.source rsp
);

  res_t held;
  logic valid;

  assign res_free = !valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_load) begin
      valid <= 1'b1;
    end else if (rsp.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      held <= res;
    end
  end

  assign rsp.valid          = valid;
  assign rsp.status         = held.status;
  assign rsp.where          = held.where;
  assign rsp.count          = held.count;
  assign rsp.out_id         = held.id;
  assign rsp.out_initiative = held.ini;
  assign rsp.out_age        = held.age;

endmodule
`default_nettype wire

// ===== hdl/bounded_sorted_priority_queue.sv =====
// Sorted priority queue of up to DEPTH entries (id, initiative, age).
// req: one beat per operation (insert, remove by id, read at position).
// rsp: one beat per operation with status, position, count and, for a
// read, the entry fields. capacity is set through cfg_we/cfg_wdata; the user
// must write it only while idle, as the block does not enforce this.
// Entries sit in a single-port-read, single-port-write RAM; the sequencer
// handles one operation at a time and reads one slot per cycle.
// Steps from req beat to rsp valid (n entries), paced by the RAM read port:
//   insert: k tail slots scanned (k <= n), lower ones moved up, then the write
//   remove: a full pass over the n entries that also closes the gap
//   read:   one slot read; dropped insert, empty remove, bad position: none
// A finished beat waits in the output register; a stalled receiver holds
// the sequencer in its final step, and req.ready stays low until the
// next operation can start.
// Reset (rst, synchronous) empties the queue and sets capacity to 16;
// RAM contents are not cleared, entries beyond the count are never read.
`default_nettype none
`include "bounded_sorted_priority_queue_macros.svh"
module bounded_sorted_priority_queue import bsq_pkg::*; #(
  parameter int DEPTH   = 16,
  parameter int ID_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  bsq_in_if.sink           req,
  bsq_out_if.source        rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int EW = ID_BITS + INI_W + AGE_W;

  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;
  res_t          res;
  logic          res_load;
  logic          res_free;

  bsq_ctrl #(
    .DEPTH   (DEPTH),
    .ID_BITS (ID_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .res       (res),
    .res_load  (res_load),
    .res_free  (res_free)
  );

  bsq_mem #(
    .DEPTH (DEPTH),
    .EW    (EW)
  ) u_mem (
    .clk   (clk),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata)
  );

  bsq_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .res_load (res_load),
    .res_free (res_free),
    .rsp      (rsp)
  );

  `BSQ_ASSERT_IMP(a_no_same_slot, mem_we && mem_re, mem_waddr != mem_raddr, "read and write hit the same slot")
  `BSQ_ASSERT_IMP(a_no_overwrite, res_load, !rsp.valid || rsp.ready, "result overwrites a waiting beat")
  `BSQ_ASSERT_NXT(a_load_shows, res_load, rsp.valid, "loaded result not presented")

endmodule
`default_nettype wire

// ===== tb/sv/bsq_tb_pkg.sv =====
package bsq_tb_pkg;
  import bsq_pkg::*;

  localparam int SLOTS = 16;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  class turn_order_scoreboard;
    logic [EXT_ID_W-1:0] slot_id  [SLOTS];
    logic [INI_W-1:0]    slot_ini [SLOTS];
    logic [AGE_W-1:0]    slot_age [SLOTS];
    int unsigned         fill;
    int unsigned         peak_fill;
    logic [CAP_W-1:0]    capacity;
    res_t                replies_due[$];
    int unsigned         mismatches;
    int unsigned         replies_seen;
    int unsigned         by_status[4];

    function new();
      fill = 0;
      peak_fill = 0;
      capacity = CAP_RESET;
      mismatches = 0;
      replies_seen = 0;
      foreach (by_status[s]) by_status[s] = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] v);
      capacity = v;
    endfunction

    function int unsigned room();
      return (capacity < SLOTS) ? int'(capacity) : SLOTS;
    endfunction

    function logic [EXT_ID_W-1:0] pick_id();
      if (fill == 0) return EXT_ID_W'($urandom);
      return slot_id[$urandom_range(0, fill - 1)];
    endfunction

    function void note_op(logic [OP_W-1:0] op, logic [EXT_ID_W-1:0] id,
                          logic [INI_W-1:0] ini, logic [AGE_W-1:0] age,
                          logic [POS_W-1:0] pos);
      res_t        r;
      int unsigned i;
      r = '0;
      r.status = ST_OK;
      case (op)
        OP_INSERT: begin
          if (fill >= room()) begin
            r.status = ST_FULL;
          end else begin
            i = 0;
            while (i < fill && !(ini > slot_ini[i] ||
                                 (ini == slot_ini[i] && age >= slot_age[i])))
              i++;
            for (int k = fill; k > i; k--) begin
              slot_id[k]  = slot_id[k-1];
              slot_ini[k] = slot_ini[k-1];
              slot_age[k] = slot_age[k-1];
            end
            slot_id[i]  = id;
            slot_ini[i] = ini;
            slot_age[i] = age;
            fill++;
            r.where = POS_W'(i);
          end
        end
        OP_REMOVE: begin
          i = 0;
          while (i < fill && slot_id[i] != id) i++;
          if (i >= fill) begin
            r.status = ST_NOT_FOUND;
          end else begin
            for (int k = i; k + 1 < fill; k++) begin
              slot_id[k]  = slot_id[k+1];
              slot_ini[k] = slot_ini[k+1];
              slot_age[k] = slot_age[k+1];
            end
            fill--;
            r.where = POS_W'(i);
          end
        end
        OP_READ: begin
          r.where = pos;
          if (pos >= fill) begin
            r.status = ST_EMPTY;
          end else begin
            r.id  = slot_id[pos];
            r.ini = slot_ini[pos];
            r.age = slot_age[pos];
          end
        end
        default: ;
      endcase
      r.count = CNT_W'(fill);
      if (fill > peak_fill) peak_fill = fill;
      by_status[r.status]++;
      replies_due.push_back(r);
    endfunction

    function void check_reply(res_t got);
      res_t want;
      replies_seen++;
      if (replies_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: reply beat with nothing outstanding (status %0d where %0d)",
                   $time, got.status, got.where);
        return;
      end
      want = replies_due.pop_front();
      if (got.status !== want.status || got.where !== want.where ||
          got.count !== want.count || got.id !== want.id ||
          got.ini !== want.ini || got.age !== want.age) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: reply mismatch exp/got: status %0d/%0d where %0d/%0d ",
                    "count %0d/%0d id %h/%h ini %h/%h age %h/%h"}, $time,
                   want.status, got.status, want.where, got.where,
                   want.count, got.count, want.id, got.id,
                   want.ini, got.ini, want.age, got.age);
      end
    endfunction
  endclass

endpackage

// ===== tb/sv/bounded_sorted_priority_queue_tb.sv =====
module bounded_sorted_priority_queue_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bsq_pkg::*;
  import bsq_tb_pkg::*;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CAP_W-1:0] cfg_wdata;

  bsq_in_if  req_if ();
  bsq_out_if rsp_if ();

  bounded_sorted_priority_queue dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  turn_order_scoreboard board;
  int unsigned          send_gap_pct;
  int unsigned          recv_gap_pct;
  bit                   hold_off_req;
  int unsigned          beats_sent;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin : reply_sink
    int unsigned stall;
    stall = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = 90;
      end else if (stall == 0 && $urandom_range(99) < recv_gap_pct) begin
        stall = $urandom_range(1, 12);
      end
      if (stall > 0) begin
        rsp_if.ready = 1'b0;
        stall--;
      end else begin
        rsp_if.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : reply_mon
    res_t got;
    if (!rst && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      got.status = rsp_if.status;
      got.where  = rsp_if.where;
      got.count  = rsp_if.count;
      got.id     = rsp_if.out_id;
      got.ini    = rsp_if.out_initiative;
      got.age    = rsp_if.out_age;
      board.check_reply(got);
    end
  end

  task automatic send_op(input logic [OP_W-1:0] op, input logic [EXT_ID_W-1:0] id,
                         input logic [INI_W-1:0] ini, input logic [AGE_W-1:0] age,
                         input logic [POS_W-1:0] pos);
    int unsigned gap;
    @(negedge clk);
    if ($urandom_range(99) < send_gap_pct) begin
      gap = $urandom_range(1, 12);
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid      = 1'b1;
    req_if.opcode     = op;
    req_if.entry_id   = id;
    req_if.initiative = ini;
    req_if.age        = age;
    req_if.position   = pos;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    board.note_op(op, id, ini, age, pos);
    beats_sent++;
  endtask

  task automatic drain_replies();
    @(negedge clk);
    req_if.valid = 1'b0;
    while (board.replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    drain_replies();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_wdata = v;
    @(posedge clk);
    board.set_capacity(v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic random_op();
    logic [OP_W-1:0]     op;
    logic [EXT_ID_W-1:0] id;
    logic [INI_W-1:0]    ini;
    logic [AGE_W-1:0]    age;
    logic [POS_W-1:0]    pos;
    int unsigned         roll;
    roll = $urandom_range(99);
    if (roll < 4)
      op = OP_SPARE;
    else if (roll < ((board.fill < board.room()) ? 50 : 28))
      op = OP_INSERT;
    else if (roll < 72)
      op = OP_REMOVE;
    else
      op = OP_READ;
    if (op == OP_REMOVE && $urandom_range(99) < 75)
      id = board.pick_id();
    else if ($urandom_range(1))
      id = EXT_ID_W'($urandom_range(0, 15));
    else
      id = EXT_ID_W'($urandom);
    ini = $urandom_range(1) ? INI_W'($urandom_range(120, 123)) : INI_W'($urandom);
    age = $urandom_range(1) ? AGE_W'($urandom_range(0, 3)) : AGE_W'($urandom);
    if (board.fill > 0 && $urandom_range(99) < 80)
      pos = POS_W'($urandom_range(0, board.fill - 1));
    else
      pos = POS_W'($urandom);
    send_op(op, id, ini, age, pos);
  endtask

  task automatic run_phase(input logic [CAP_W-1:0] cap, input int unsigned beats,
                           input int unsigned tx_pct, input int unsigned rx_pct);
    write_capacity(cap);
    send_gap_pct = tx_pct;
    recv_gap_pct = rx_pct;
    repeat (beats) random_op();
  endtask

  initial begin
    board             = new();
    beats_sent        = 0;
    hold_off_req      = 1'b0;
    send_gap_pct      = 0;
    recv_gap_pct      = 0;
    req_if.valid      = 1'b0;
    req_if.opcode     = OP_INSERT;
    req_if.entry_id   = '0;
    req_if.initiative = '0;
    req_if.age        = '0;
    req_if.position   = '0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    rst               = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_gap_pct = 20;
    recv_gap_pct = 20;
    // empty queue, extremes, tie ordering, duplicate ids, reads past the end
    send_op(OP_REMOVE, 16'h0000, 8'h00, 16'h0000, 4'd0);
    send_op(OP_READ,   16'h0000, 8'h00, 16'h0000, 4'd0);
    send_op(OP_INSERT, 16'hffff, 8'hff, 16'hffff, 4'd0);
    send_op(OP_INSERT, 16'h0000, 8'h00, 16'h0000, 4'd0);
    send_op(OP_INSERT, 16'h0001, 8'd100, 16'd5, 4'd0);
    send_op(OP_INSERT, 16'h0002, 8'd100, 16'd5, 4'd0);
    send_op(OP_INSERT, 16'h0003, 8'd100, 16'd9, 4'd0);
    send_op(OP_INSERT, 16'h0004, 8'd100, 16'd1, 4'd0);
    send_op(OP_INSERT, 16'h0001, 8'd50, 16'h8000, 4'd0);
    send_op(OP_INSERT, 16'h0005, 8'hff, 16'h0000, 4'd0);
    send_op(OP_READ,   16'h0000, 8'h00, 16'h0000, 4'd0);
    send_op(OP_READ,   16'h0000, 8'h00, 16'h0000, 4'd1);
    send_op(OP_READ,   16'h0000, 8'h00, 16'h0000, 4'd2);
    send_op(OP_READ,   16'h0000, 8'h00, 16'h0000, 4'd3);
    send_op(OP_READ,   16'hffff, 8'hff, 16'hffff, 4'd15);
    send_op(OP_REMOVE, 16'h0001, 8'h00, 16'h0000, 4'd0);
    send_op(OP_REMOVE, 16'h1234, 8'h00, 16'h0000, 4'd0);
    send_op(OP_SPARE,  16'hffff, 8'hff, 16'hffff, 4'd15);
    send_op(OP_REMOVE, 16'hffff, 8'h00, 16'h0000, 4'd0);
    send_op(OP_READ,   16'h0000, 8'h00, 16'h0000, 4'd0);
    send_op(OP_REMOVE, 16'h0000, 8'h00, 16'h0000, 4'd0);

    run_phase(5'd0, 60, 20, 20);
    run_phase(5'd1, 150, 15, 15);
    run_phase(5'd31, 100, 10, 10);
    hold_off_req = 1'b1;
    repeat (200) random_op();
    run_phase(5'd16, 200, 0, 0);
    run_phase(CAP_W'($urandom_range(2, 15)), 300, 30, 10);
    run_phase(CAP_W'($urandom_range(17, 30)), 300, 10, 30);
    run_phase(5'd4, 220, 20, 20);
    // closing stretch at full speed on both sides
    run_phase(5'd16, 300, 0, 0);

    drain_replies();
    repeat (30) @(posedge clk);

    $display("Ran %0d beats over capacities 0..31: %0d ok, %0d dropped full,",
             beats_sent, board.by_status[ST_OK], board.by_status[ST_FULL]);
    $display("%0d id misses, %0d reads past the end; deepest queue %0d, %0d mismatches",
             board.by_status[ST_NOT_FOUND], board.by_status[ST_EMPTY],
             board.peak_fill, board.mismatches);
    if (board.mismatches == 0 && board.replies_due.size() == 0 &&
        board.replies_seen == beats_sent)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/bsq_pkg.sv
hdl/bsq_if.sv
hdl/bsq_mem.sv
hdl/bsq_ctrl.sv
hdl/bsq_out_stage.sv
hdl/bounded_sorted_priority_queue.sv
tb/sv/bsq_tb_pkg.sv
tb/sv/bounded_sorted_priority_queue_tb.sv
